// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Clocked implication and invariant checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define AIC_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// cond must hold at every clock edge out of reset.
`define AIC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

// ----- src/aic_pkg.sv -----
// ----------------------------------------------------------------------------
// aic_pkg
// Class codes, group codes and stage payload types of the instruction classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package aic_pkg;

    // Number of ordered match patterns (one per known class)
    localparam int NUM_PATTERNS = 28;

    // Class codes in match priority order
    typedef enum logic [4:0] {
        CLS_ADRP    = 5'd0,
        CLS_ADR     = 5'd1,
        CLS_ADD     = 5'd2,
        CLS_SUB     = 5'd3,
        CLS_BL      = 5'd4,
        CLS_CBZ     = 5'd5,
        CLS_RET     = 5'd6,
        CLS_TBNZ    = 5'd7,
        CLS_BR      = 5'd8,
        CLS_LDR     = 5'd9,
        CLS_CBNZ    = 5'd10,
        CLS_MOVK    = 5'd11,
        CLS_ORR     = 5'd12,
        CLS_AND     = 5'd13,
        CLS_TBZ     = 5'd14,
        CLS_LDXR    = 5'd15,
        CLS_LDRB    = 5'd16,
        CLS_STR     = 5'd17,
        CLS_STP     = 5'd18,
        CLS_MOVZ    = 5'd19,
        CLS_MOV     = 5'd20,
        CLS_BCOND   = 5'd21,
        CLS_B       = 5'd22,
        CLS_NOP     = 5'd23,
        CLS_CSEL    = 5'd24,
        CLS_MRS     = 5'd25,
        CLS_SUBS    = 5'd26,
        CLS_CCMP    = 5'd27,
        CLS_UNKNOWN = 5'd28
    } insn_class_t;

    // Coarse groups
    typedef enum logic [1:0] {
        GRP_GENERAL = 2'd0,
        GRP_BRANCH  = 2'd1,
        GRP_MEMORY  = 2'd2
    } insn_group_t;

    // Stage 1 -> 2: raw word and per-pattern hits
    typedef struct packed {
        logic [31:0]             word;
        logic [NUM_PATTERNS-1:0] hits;
    } aic_hits_t;

    // Stage 2 -> 3: raw word and winning class
    typedef struct packed {
        logic [31:0] word;
        insn_class_t cls;
    } aic_cls_t;

    // Final result item
    typedef struct packed {
        logic        rm_present;
        logic [4:0]  rm_reg;
        logic        rd_present;
        logic [4:0]  rd_reg;
        logic        rn_present;
        logic [4:0]  rn_reg;
        insn_group_t insn_group;
        insn_class_t insn_class;
    } aic_result_t;

    // Per-class attributes
    typedef struct packed {
        insn_group_t grp;
        logic        has_rn;
        logic        has_rd;
        logic        has_rm;
    } aic_attr_t;

    function automatic aic_attr_t class_attr(input insn_class_t cls);
        aic_attr_t a;
        a = '{grp: GRP_GENERAL, has_rn: 1'b0, has_rd: 1'b0, has_rm: 1'b0};
        unique case (cls)
            CLS_ADRP, CLS_ADR, CLS_MOVK, CLS_MOVZ: begin
                a.has_rd = 1'b1;
            end
            CLS_ADD, CLS_SUB, CLS_ORR, CLS_AND: begin
                a.has_rn = 1'b1;
                a.has_rd = 1'b1;
            end
            CLS_RET, CLS_BR: begin
                a.has_rn = 1'b1;
            end
            CLS_LDR, CLS_LDXR, CLS_LDRB, CLS_STR, CLS_STP: begin
                a.grp    = GRP_MEMORY;
                a.has_rn = 1'b1;
            end
            CLS_BL, CLS_CBZ, CLS_CBNZ, CLS_TBZ, CLS_TBNZ, CLS_BCOND, CLS_B: begin
                a.grp = GRP_BRANCH;
            end
            CLS_MOV, CLS_CSEL, CLS_SUBS: begin
                a.has_rn = 1'b1;
                a.has_rd = 1'b1;
                a.has_rm = 1'b1;
            end
            CLS_CCMP: begin
                a.has_rn = 1'b1;
                a.has_rm = 1'b1;
            end
            CLS_NOP, CLS_MRS, CLS_UNKNOWN: begin
                a.grp = GRP_GENERAL;
            end
            default: begin
                a.grp = GRP_GENERAL;
            end
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- src/aic_match.sv -----
// ----------------------------------------------------------------------------
// aic_match
// Stage 1: tests the word against every class pattern in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module aic_match import aic_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] in_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output aic_hits_t        out_data
);

    logic [NUM_PATTERNS-1:0] hits;
    logic [9:0]              top10_or;
    logic                    advance;
    logic                    valid_reg;
    logic                    valid_next;
    aic_hits_t               data_reg;
    aic_hits_t               data_next;

    // Top ten bits with bit 30 forced, used by the load patterns
    assign top10_or = {in_word[31], 1'b1, in_word[29:22]};

    // One hit per class pattern; priority is resolved in the next stage
    always_comb begin
        hits = '0;
        hits[CLS_ADRP]  = (in_word[28:24] == 5'h10) && in_word[31];
        hits[CLS_ADR]   = (in_word[28:24] == 5'h10);
        hits[CLS_ADD]   = (in_word[30:24] == 7'h11);
        hits[CLS_SUB]   = (in_word[30:24] == 7'h51);
        hits[CLS_BL]    = (in_word[31:26] == 6'h25);
        hits[CLS_CBZ]   = (in_word[30:24] == 7'h34);
        hits[CLS_RET]   = ((in_word | 32'h0000_03E0) == 32'hD65F_03E0);
        hits[CLS_TBNZ]  = (in_word[30:24] == 7'h37);
        hits[CLS_BR]    = ((in_word | 32'h0000_03E0) == 32'hD61F_03E0);
        hits[CLS_LDR]   = ((top10_or == 10'h3E1) && (in_word[11:10] != 2'b00))
                        || (top10_or == 10'h3E5)
                        || (in_word[31:23] == 9'h018);
        hits[CLS_CBNZ]  = (in_word[30:24] == 7'h35);
        hits[CLS_MOVK]  = (in_word[30:23] == 8'hE5);
        hits[CLS_ORR]   = (in_word[30:23] == 8'h64);
        hits[CLS_AND]   = (in_word[30:23] == 8'h24);
        hits[CLS_TBZ]   = (in_word[30:24] == 7'h36);
        hits[CLS_LDXR]  = (in_word[29:24] == 6'h08) && in_word[31] && in_word[22];
        hits[CLS_LDRB]  = (in_word[31:21] == 11'h1C2)
                        || (in_word[31:22] == 10'h0E5)
                        || ((in_word[31:21] == 11'h1C3) && (in_word[11:10] == 2'b10));
        hits[CLS_STR]   = (in_word[29:22] == 8'hE4) && in_word[31];
        hits[CLS_STP]   = (in_word[30:25] == 6'h14) && !in_word[22];
        hits[CLS_MOVZ]  = (in_word[30:23] == 8'hA5);
        hits[CLS_MOV]   = (in_word[30:24] == 7'h2A) && !in_word[21];
        hits[CLS_BCOND] = (in_word[31:24] == 8'h54) && !in_word[4];
        hits[CLS_B]     = (in_word[31:26] == 6'h05);
        hits[CLS_NOP]   = (in_word[31:12] == 20'hD5032);
        hits[CLS_CSEL]  = (in_word[30:21] == 10'h0D4) && (in_word[11:10] == 2'b00);
        hits[CLS_MRS]   = (in_word[31:20] == 12'hD53);
        hits[CLS_SUBS]  = (in_word[30:21] == 10'h359)
                        || (in_word[30:24] == 7'h6B)
                        || (in_word[30:24] == 7'h71);
        hits[CLS_CCMP]  = (in_word[30:21] == 10'h3D2);
    end

    // Stage register moves when empty or when downstream takes its item
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (advance) begin
            valid_next = in_valid;
            data_next  = '{word: in_word, hits: hits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/aic_prio.sv -----
// ----------------------------------------------------------------------------
// aic_prio
// Stage 2: picks the first matching pattern and encodes its class code.
// ----------------------------------------------------------------------------
`default_nettype none

module aic_prio import aic_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  aic_hits_t      in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output aic_cls_t       out_data
);

    logic [NUM_PATTERNS-1:0] first_hit;
    logic [4:0]              hit_idx;
    insn_class_t             cls;
    logic                    advance;
    logic                    valid_reg;
    logic                    valid_next;
    aic_cls_t                data_reg;
    aic_cls_t                data_next;

    // Isolate the lowest set hit: lowest index has highest priority
    assign first_hit = in_data.hits & (~in_data.hits + NUM_PATTERNS'(1));

    // One-hot to binary, each output bit an OR over independent positions
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (first_hit[i]) begin
                hit_idx = hit_idx | 5'(i);
            end
        end
    end

    assign cls = (in_data.hits == '0) ? CLS_UNKNOWN : insn_class_t'(hit_idx);

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (advance) begin
            valid_next = in_valid;
            data_next  = '{word: in_data.word, cls: cls};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/aic_attr.sv -----
// ----------------------------------------------------------------------------
// aic_attr
// Stage 3: looks up group and operand presence, masks the register fields.
// ----------------------------------------------------------------------------
`default_nettype none

module aic_attr import aic_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  aic_cls_t       in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output aic_result_t    out_data
);

    aic_attr_t   attr;
    aic_result_t result;
    logic        advance;
    logic        valid_reg;
    logic        valid_next;
    aic_result_t data_reg;
    aic_result_t data_next;

    assign attr = class_attr(in_data.cls);

    // Absent operands read as zero
    always_comb begin
        result.insn_class = in_data.cls;
        result.insn_group = attr.grp;
        result.rn_present = attr.has_rn;
        result.rn_reg     = attr.has_rn ? in_data.word[9:5] : 5'd0;
        result.rd_present = attr.has_rd;
        result.rd_reg     = attr.has_rd ? in_data.word[4:0] : 5'd0;
        result.rm_present = attr.has_rm;
        result.rm_reg     = attr.has_rm ? in_data.word[20:16] : 5'd0;
    end

    // Output register; holds its item while the receiver stalls
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (advance) begin
            valid_next = in_valid;
            data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/aarch64_insn_classifier.sv -----
// AArch64 instruction classifier.
// Input stream: one 32-bit instruction word per transfer on s_tdata.
// Output stream: one result per input word on m_tdata: class code (28 known
// classes in first-match priority order, or unknown), coarse group (general,
// branch immediate, memory) and the Rn, Rd and Rm numbers with presence
// flags; a register field whose flag is clear reads zero.
// Pipeline: three register stages (pattern match, priority encode, attribute
// lookup) lie between the input transfer and m_tvalid.
// Throughput: one word per cycle sustained while m_tready stays high.
// Stalls: each stage advances when it is empty or its successor takes its
// item, so bubbles are squeezed out; with m_tready low the result holds on
// m_tdata and s_tready falls once all three stages are full.
// Reset: aresetn (synchronous, active low) empties the pipeline; no state
// survives between words.
// ----------------------------------------------------------------------------
// aarch64_insn_classifier
// Top level: three-stage streaming instruction classifier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aarch64_insn_classifier import aic_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instr_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [4:0] insn_class, [6:5] insn_group, [11:7] rn_reg, [12] rn_present,
    // [17:13] rd_reg, [18] rd_present, [23:19] rm_reg, [24] rm_present,
    // [31:25] zero
    output logic [31:0]      m_tdata
);

    logic        s1_valid;
    logic        s1_ready;
    aic_hits_t   s1_data;
    logic        s2_valid;
    logic        s2_ready;
    aic_cls_t    s2_data;
    aic_result_t s3_data;

    // Stage 1: pattern match
    aic_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage 2: priority encode
    aic_prio u_prio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: attributes and output register
    aic_attr u_attr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (s3_data)
    );

    assign m_tdata = {7'd0, s3_data};

    // Checks
    `AIC_ASSERT_IMPLIES(a_unknown_bare, aclk, aresetn,
        m_tvalid && (s3_data.insn_class == CLS_UNKNOWN),
        !s3_data.rn_present && !s3_data.rd_present && !s3_data.rm_present
        && (s3_data.insn_group == GRP_GENERAL),
        "unknown class carries operands or a group")
    `AIC_ASSERT_IMPLIES(a_branch_no_regs, aclk, aresetn,
        m_tvalid && (s3_data.insn_group == GRP_BRANCH),
        !s3_data.rn_present && !s3_data.rd_present && !s3_data.rm_present,
        "branch-immediate result has register operands")
    `AIC_ASSERT_ALWAYS(a_absent_zero, aclk, aresetn,
        !m_tvalid
        || ((s3_data.rn_present || (s3_data.rn_reg == 5'd0))
        && (s3_data.rd_present || (s3_data.rd_reg == 5'd0))
        && (s3_data.rm_present || (s3_data.rm_reg == 5'd0))),
        "absent operand field is not zero")
    `AIC_ASSERT_IMPLIES(a_backpressure_src, aclk, aresetn,
        !s_tready,
        m_tvalid && !m_tready,
        "input stalled without a stalled output")

endmodule

`default_nettype wire

// ----- tb/aic_decode_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aic_decode_checker
// Watches both stream channels of the instruction classifier. Every word taken
// on the input side is decoded here into its expected class, group and
// register operands. Every result transfer is compared with the oldest pending
// decode. Mismatches, results nobody asked for and the number of decodes still
// waiting are handed to the testbench top.
// ----------------------------------------------------------------------------

module aic_decode_checker import aic_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instr_word
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [4:0] insn_class, [6:5] insn_group, [11:7] rn_reg, [12] rn_present,
    // [17:13] rd_reg, [18] rd_present, [23:19] rm_reg, [24] rm_present
    input  wire logic [31:0] m_tdata,
    output int               mismatch_count,
    output int               pending_count
);

    localparam int REPORT_LIMIT = 10;

    // Word as it went in, with the result it must produce
    typedef struct packed {
        logic [31:0] word;
        aic_result_t res;
    } decoded_t;

    decoded_t    decoded_q[$];
    decoded_t    oldest;
    aic_result_t seen;
    int          err_total = 0;
    int          queued    = 0;

    assign mismatch_count = err_total;
    assign pending_count  = queued;

    // Ordered first-match pattern list; the first hit decides the class
    function automatic insn_class_t match_class(input logic [31:0] w);
        if (w[28:24] == 5'h10 && w[31])                        return CLS_ADRP;
        if (w[28:24] == 5'h10)                                 return CLS_ADR;
        if (w[30:24] == 7'h11)                                 return CLS_ADD;
        if (w[30:24] == 7'h51)                                 return CLS_SUB;
        if (w[31:26] == 6'h25)                                 return CLS_BL;
        if (w[30:24] == 7'h34)                                 return CLS_CBZ;
        if ((w | 32'h0000_03E0) == 32'hD65F_03E0)              return CLS_RET;
        if (w[30:24] == 7'h37)                                 return CLS_TBNZ;
        if ((w | 32'h0000_03E0) == 32'hD61F_03E0)              return CLS_BR;
        // load register: unsigned offset, pre/post index, or literal forms
        if (((w[31:22] | 10'h100) == 10'h3E1 && w[11:10] != 2'b00) ||
            (w[31:22] | 10'h100) == 10'h3E5 || w[31:23] == 9'h018)
                                                               return CLS_LDR;
        if (w[30:24] == 7'h35)                                 return CLS_CBNZ;
        if (w[30:23] == 8'hE5)                                 return CLS_MOVK;
        if (w[30:23] == 8'h64)                                 return CLS_ORR;
        if (w[30:23] == 8'h24)                                 return CLS_AND;
        if (w[30:24] == 7'h36)                                 return CLS_TBZ;
        if (w[29:24] == 6'h08 && w[31] && w[22])               return CLS_LDXR;
        if (w[31:21] == 11'h1C2 || w[31:22] == 10'h0E5 ||
            (w[31:21] == 11'h1C3 && w[11:10] == 2'b10))        return CLS_LDRB;
        if (w[29:22] == 8'hE4 && w[31])                        return CLS_STR;
        if (w[30:25] == 6'h14 && !w[22])                       return CLS_STP;
        if (w[30:23] == 8'hA5)                                 return CLS_MOVZ;
        if (w[30:24] == 7'h2A && !w[21])                       return CLS_MOV;
        if (w[31:24] == 8'h54 && !w[4])                        return CLS_BCOND;
        if (w[31:26] == 6'h05)                                 return CLS_B;
        if (w[31:12] == 20'hD5032)                             return CLS_NOP;
        if (w[30:21] == 10'h0D4 && w[11:10] == 2'b00)          return CLS_CSEL;
        if (w[31:20] == 12'hD53)                               return CLS_MRS;
        if (w[30:21] == 10'h359 || w[30:24] == 7'h6B ||
            w[30:24] == 7'h71)                                 return CLS_SUBS;
        if (w[30:21] == 10'h3D2)                               return CLS_CCMP;
        return CLS_UNKNOWN;
    endfunction

    // Full result: class, group and the operands that the class defines
    function automatic aic_result_t decode_word(input logic [31:0] w);
        aic_result_t r;
        r            = '0;
        r.insn_class = match_class(w);

        case (r.insn_class)
            CLS_BL, CLS_CBZ, CLS_CBNZ, CLS_TBZ, CLS_TBNZ, CLS_BCOND, CLS_B:
                r.insn_group = GRP_BRANCH;
            CLS_LDR, CLS_LDRB, CLS_LDXR, CLS_STR, CLS_STP:
                r.insn_group = GRP_MEMORY;
            default:
                r.insn_group = GRP_GENERAL;
        endcase

        case (r.insn_class)
            CLS_SUBS, CLS_ADD, CLS_SUB, CLS_RET, CLS_BR, CLS_ORR, CLS_AND, CLS_LDXR,
            CLS_LDRB, CLS_STR, CLS_LDR, CLS_STP, CLS_CSEL, CLS_MOV, CLS_CCMP: begin
                r.rn_present = 1'b1;
                r.rn_reg     = w[9:5];
            end
            default: ;
        endcase

        case (r.insn_class)
            CLS_SUBS, CLS_ADRP, CLS_ADR, CLS_ADD, CLS_SUB, CLS_MOVK, CLS_ORR,
            CLS_AND, CLS_MOVZ, CLS_MOV, CLS_CSEL: begin
                r.rd_present = 1'b1;
                r.rd_reg     = w[4:0];
            end
            default: ;
        endcase

        case (r.insn_class)
            CLS_CCMP, CLS_CSEL, CLS_MOV, CLS_SUBS: begin
                r.rm_present = 1'b1;
                r.rm_reg     = w[20:16];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Retire results first, then record the new input word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen = aic_result_t'(m_tdata[24:0]);
                if (decoded_q.size() == 0) begin
                    if (err_total < REPORT_LIMIT)
                        $display("%t: unexpected result transfer %h", $realtime, m_tdata);
                    err_total <= err_total + 1;
                end else begin
                    oldest = decoded_q.pop_front();
                    if (seen.insn_class !== oldest.res.insn_class ||
                        seen.insn_group !== oldest.res.insn_group ||
                        seen.rn_reg     !== oldest.res.rn_reg     ||
                        seen.rn_present !== oldest.res.rn_present ||
                        seen.rd_reg     !== oldest.res.rd_reg     ||
                        seen.rd_present !== oldest.res.rd_present ||
                        seen.rm_reg     !== oldest.res.rm_reg     ||
                        seen.rm_present !== oldest.res.rm_present ||
                        m_tdata[31:25]  !== 7'd0) begin
                        if (err_total < REPORT_LIMIT) begin
                            $display("%t: word %h mismatch", $realtime, oldest.word);
                            $display("  exp cls=%0d grp=%0d rn=%0d/%b rd=%0d/%b rm=%0d/%b",
                                     oldest.res.insn_class, oldest.res.insn_group,
                                     oldest.res.rn_reg, oldest.res.rn_present,
                                     oldest.res.rd_reg, oldest.res.rd_present,
                                     oldest.res.rm_reg, oldest.res.rm_present);
                            $display("  got cls=%0d grp=%0d rn=%0d/%b rd=%0d/%b rm=%0d/%b pad=%h",
                                     seen.insn_class, seen.insn_group,
                                     seen.rn_reg, seen.rn_present,
                                     seen.rd_reg, seen.rd_present,
                                     seen.rm_reg, seen.rm_present, m_tdata[31:25]);
                        end
                        err_total <= err_total + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decoded_q.push_back('{word: s_tdata, res: decode_word(s_tdata)});
        end
        queued <= decoded_q.size();
    end

endmodule

// ----- tb/tb_aarch64_insn_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aarch64_insn_classifier
// Stimulus and verdict for the instruction classifier. A directed pass sends
// one word per class with all register fields set, plus all-zeros and
// all-ones. The random pass mostly aims words at a random class with random
// free bits, the rest fully random. The sender runs in bursts with gaps, the
// receiver stalls on its own pattern; the checker beside the block predicts.
// ----------------------------------------------------------------------------

module tb_aarch64_insn_classifier import aic_pkg::*; ();

    localparam int RAND_ITEMS     = 420;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    // Receiver behavior per phase
    localparam int RDY_OPEN   = 0;
    localparam int RDY_STALL  = 1;
    localparam int RDY_JITTER = 2;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // [31:0] instr_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [4:0] insn_class, [6:5] insn_group, [11:7] rn_reg, [12] rn_present,
    // [17:13] rd_reg, [18] rd_present, [23:19] rm_reg, [24] rm_present
    logic [31:0] m_tdata;

    int          mismatch_count;
    int          pending_count;
    int unsigned quiet_cycles = 0;
    int unsigned rdy_left     = 0;
    int          rdy_mode     = RDY_OPEN;

    aarch64_insn_classifier i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    aic_decode_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Word aimed at one class: fixed bits from the pattern, free bits from fill.
    // Classes with several encodings pick one by form.
    function automatic logic [31:0] aim_word(input insn_class_t cls, input int unsigned form,
                                             input logic [31:0] fill);
        logic [31:0] care;
        logic [31:0] val;
        care = 32'hFFFF_FFFF;
        val  = fill;
        case (cls)
            CLS_ADRP:  begin care = 32'h9F00_0000; val = 32'h9000_0000; end
            CLS_ADR:   begin care = 32'h9F00_0000; val = 32'h1000_0000; end
            CLS_ADD:   begin care = 32'h7F00_0000; val = 32'h1100_0000; end
            CLS_SUB:   begin care = 32'h7F00_0000; val = 32'h5100_0000; end
            CLS_BL:    begin care = 32'hFC00_0000; val = 32'h9400_0000; end
            CLS_CBZ:   begin care = 32'h7F00_0000; val = 32'h3400_0000; end
            CLS_RET:   begin care = 32'hFFFF_FC1F; val = 32'hD65F_0000; end
            CLS_TBNZ:  begin care = 32'h7F00_0000; val = 32'h3700_0000; end
            CLS_BR:    begin care = 32'hFFFF_FC1F; val = 32'hD61F_0000; end
            CLS_LDR: begin
                case (form % 3)
                    0:       begin care = 32'hBFC0_0000; val = 32'hB940_0000; end
                    1:       begin care = 32'hBFC0_0000; val = 32'hB840_0000; end
                    default: begin care = 32'hFF80_0000; val = 32'h0C00_0000; end
                endcase
            end
            CLS_CBNZ:  begin care = 32'h7F00_0000; val = 32'h3500_0000; end
            CLS_MOVK:  begin care = 32'h7F80_0000; val = 32'h7280_0000; end
            CLS_ORR:   begin care = 32'h7F80_0000; val = 32'h3200_0000; end
            CLS_AND:   begin care = 32'h7F80_0000; val = 32'h1200_0000; end
            CLS_TBZ:   begin care = 32'h7F00_0000; val = 32'h3600_0000; end
            CLS_LDXR:  begin care = 32'hBF40_0000; val = 32'h8840_0000; end
            CLS_LDRB: begin
                case (form % 3)
                    0:       begin care = 32'hFFE0_0000; val = 32'h3840_0000; end
                    1:       begin care = 32'hFFC0_0000; val = 32'h3940_0000; end
                    default: begin care = 32'hFFE0_0C00; val = 32'h3860_0800; end
                endcase
            end
            CLS_STR:   begin care = 32'hBFC0_0000; val = 32'hB900_0000; end
            CLS_STP:   begin care = 32'h7E40_0000; val = 32'h2800_0000; end
            CLS_MOVZ:  begin care = 32'h7F80_0000; val = 32'h5280_0000; end
            CLS_MOV:   begin care = 32'h7F20_0000; val = 32'h2A00_0000; end
            CLS_BCOND: begin care = 32'hFF00_0010; val = 32'h5400_0000; end
            CLS_B:     begin care = 32'hFC00_0000; val = 32'h1400_0000; end
            CLS_NOP:   begin care = 32'hFFFF_F000; val = 32'hD503_2000; end
            CLS_CSEL:  begin care = 32'h7FE0_0C00; val = 32'h1A80_0000; end
            CLS_MRS:   begin care = 32'hFFF0_0000; val = 32'hD530_0000; end
            CLS_SUBS: begin
                case (form % 3)
                    0:       begin care = 32'h7FE0_0000; val = 32'h6B20_0000; end
                    1:       begin care = 32'h7F00_0000; val = 32'h6B00_0000; end
                    default: begin care = 32'h7F00_0000; val = 32'h7100_0000; end
                endcase
            end
            CLS_CCMP:  begin care = 32'h7FE0_0000; val = 32'h7A40_0000; end
            default: ;
        endcase
        return val | (fill & ~care);
    endfunction

    // One input transfer; valid stays up for a following word
    task automatic issue_word(input logic [31:0] w);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the input off until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Receiver: open, stalled and jittery phases of random length
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(RDY_OPEN, RDY_JITTER);
            rdy_left = (rdy_mode == RDY_STALL) ? $urandom_range(1, 20) : $urandom_range(8, 60);
        end
        rdy_left = rdy_left - 1;
        case (rdy_mode)
            RDY_OPEN:  m_tready <= 1'b1;
            RDY_STALL: m_tready <= 1'b0;
            default:   m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned burst_left;
        logic [31:0] w;

        burst_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each class with every register field at its maximum
        for (int k = 0; k < NUM_PATTERNS; k++)
            issue_word(aim_word(insn_class_t'(k), 0, 32'h001F_03FF));
        issue_word(32'h0000_0000);
        issue_word(32'hFFFF_FFFF);
        drain_results();

        // Random: mostly class-aimed words, some raw noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
                drain_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            burst_left = burst_left - 1;
            if ($urandom_range(0, 4) != 0)
                w = aim_word(insn_class_t'($urandom_range(0, NUM_PATTERNS - 1)),
                             $urandom, $urandom);
            else
                w = $urandom;
            issue_word(w);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
